// File: rtl/core/http_get_request_parser_top_defines.svh
// assertion macros shared by the http get request parser rtl
// depends on nothing; included by the core and the top level
`ifndef HTTP_GET_REQUEST_PARSER_TOP_DEFINES_SVH
`define HTTP_GET_REQUEST_PARSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HGRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgrp assertion failed");

// next-cycle implication, checked outside reset
`define HGRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgrp assertion failed");

`endif

// File: rtl/core/hgrp_pkg.sv
// types, constants and character helpers of the http get request parser
// depends on nothing; used by hgrp_core and http_get_request_parser_top
package hgrp_pkg;

    localparam int unsigned MAX_REQUEST_BYTES_DEF = 2048;
    localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int RESULT_W = 56;

    typedef enum logic [14:0] {
        PH_METHOD  = 15'h0001,
        PH_GAP1    = 15'h0002,
        PH_URL     = 15'h0004,
        PH_GAP2    = 15'h0008,
        PH_VERSION = 15'h0010,
        PH_HNAME   = 15'h0020,
        PH_HSKIP   = 15'h0040,
        PH_CWS     = 15'h0080,
        PH_CVAL    = 15'h0100,
        PH_LWS     = 15'h0200,
        PH_LVAL    = 15'h0400,
        PH_BODY    = 15'h0800,
        PH_DONE    = 15'h1000,
        PH_BAD     = 15'h2000,
        PH_LONG    = 15'h4000
    } phase_t;

    typedef struct packed {
        logic [10:0] url_length;
        logic [10:0] url_offset;
        logic [30:0] body_length;
        logic        keep_alive;
        logic [1:0]  parse_status;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] get_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return "g";
            4'd1:    return "e";
            4'd2:    return "t";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ver_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return "h";
            4'd1:    return "t";
            4'd2:    return "t";
            4'd3:    return "p";
            4'd4:    return "/";
            4'd5:    return "1";
            4'd6:    return ".";
            4'd7:    return "1";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] pfx_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return "h";
            4'd1:    return "t";
            4'd2:    return "t";
            4'd3:    return "p";
            4'd4:    return ":";
            4'd5:    return "/";
            4'd6:    return "/";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] conn_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return "c";
            4'd1:    return "o";
            4'd2:    return "n";
            4'd3:    return "n";
            4'd4:    return "e";
            4'd5:    return "c";
            4'd6:    return "t";
            4'd7:    return "i";
            4'd8:    return "o";
            4'd9:    return "n";
            4'd10:   return ":";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return "c";
            4'd1:    return "o";
            4'd2:    return "n";
            4'd3:    return "t";
            4'd4:    return "e";
            4'd5:    return "n";
            4'd6:    return "t";
            4'd7:    return "-";
            4'd8:    return "l";
            4'd9:    return "e";
            4'd10:   return "n";
            4'd11:   return "g";
            4'd12:   return "t";
            4'd13:   return "h";
            4'd14:   return ":";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ka_char(input logic [3:0] idx);
        case (idx)
            4'd0:    return "k";
            4'd1:    return "e";
            4'd2:    return "e";
            4'd3:    return "p";
            4'd4:    return "-";
            4'd5:    return "a";
            4'd6:    return "l";
            4'd7:    return "i";
            4'd8:    return "v";
            4'd9:    return "e";
            default: return 8'h00;
        endcase
    endfunction

endpackage

// File: rtl/core/hgrp_core.sv
// parse state registers and per-byte next-state logic of the request parser
// depends on hgrp_pkg and http_get_request_parser_top_defines.svh
module hgrp_core #(
    parameter int unsigned MAX_REQUEST_BYTES = hgrp_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        data_byte,
    input  logic              new_request,
    output hgrp_pkg::result_t result
);
    import hgrp_pkg::*;
    `include "http_get_request_parser_top_defines.svh"

    localparam int OFF_W = $clog2(MAX_REQUEST_BYTES + 1);
    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(MAX_REQUEST_BYTES);

    phase_t            phase_reg, phase_next, phase_cur;
    logic [OFF_W-1:0]  byte_offset_reg, byte_offset_next, byte_offset_cur;
    logic [3:0]        match_index_reg, match_index_next, match_index_cur;
    logic [1:0]        cand_reg, cand_next, cand_cur;
    logic              value_ok_reg, value_ok_next, value_ok_cur;
    logic              prev_cr_reg, prev_cr_next, prev_cr_cur;
    logic [30:0]       len_acc_reg, len_acc_next, len_acc_cur;
    logic [30:0]       body_count_reg, body_count_next, body_count_cur;
    logic              ka_reg, ka_next, ka_cur;
    logic [OFF_W-1:0]  url_start_reg, url_start_next, url_start_cur;
    logic [OFF_W-1:0]  url_len_reg, url_len_next, url_len_cur;
    logic              line_empty_reg, line_empty_next, line_empty_cur;

    logic [7:0]        lc;
    logic              ws;
    logic              is_digit;
    logic [30:0]       digit;
    logic [34:0]       len_prod;
    logic              final_phase;

    // current state after an optional clear by new_request
    always_comb
    begin
        if (new_request)
        begin
            phase_cur       = PH_METHOD;
            byte_offset_cur = '0;
            match_index_cur = '0;
            cand_cur        = 2'b11;
            value_ok_cur    = 1'b1;
            prev_cr_cur     = 1'b0;
            len_acc_cur     = '0;
            body_count_cur  = '0;
            ka_cur          = 1'b0;
            url_start_cur   = '0;
            url_len_cur     = '0;
            line_empty_cur  = 1'b1;
        end
        else
        begin
            phase_cur       = phase_reg;
            byte_offset_cur = byte_offset_reg;
            match_index_cur = match_index_reg;
            cand_cur        = cand_reg;
            value_ok_cur    = value_ok_reg;
            prev_cr_cur     = prev_cr_reg;
            len_acc_cur     = len_acc_reg;
            body_count_cur  = body_count_reg;
            ka_cur          = ka_reg;
            url_start_cur   = url_start_reg;
            url_len_cur     = url_len_reg;
            line_empty_cur  = line_empty_reg;
        end
    end

    assign lc       = to_lower(data_byte);
    assign ws       = (data_byte == CH_SP) || (data_byte == CH_TAB);
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign digit    = 31'(data_byte - CH_ZERO);
    assign len_prod = ({4'd0, len_acc_cur} << 3) + ({4'd0, len_acc_cur} << 1) + 35'(digit);
    assign final_phase = (phase_cur == PH_DONE) || (phase_cur == PH_BAD)
                         || (phase_cur == PH_LONG);

    always_comb
    begin
        phase_next       = phase_cur;
        byte_offset_next = byte_offset_cur;
        match_index_next = match_index_cur;
        cand_next        = cand_cur;
        value_ok_next    = value_ok_cur;
        prev_cr_next     = prev_cr_cur;
        len_acc_next     = len_acc_cur;
        body_count_next  = body_count_cur;
        ka_next          = ka_cur;
        url_start_next   = url_start_cur;
        url_len_next     = url_len_cur;
        line_empty_next  = line_empty_cur;

        if (!final_phase)
        begin
            if (byte_offset_cur >= OFF_LIMIT)
            begin
                phase_next = PH_LONG;
            end
            else
            begin
                byte_offset_next = byte_offset_cur + 1'b1;
                if (phase_cur == PH_BODY)
                begin
                    body_count_next = body_count_cur + 1'b1;
                    if (body_count_next >= len_acc_cur)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                else if (prev_cr_cur)
                begin
                    prev_cr_next = 1'b0;
                    if (data_byte != CH_LF)
                    begin
                        phase_next = PH_BAD;
                    end
                    else
                    begin
                        // line end
                        case (phase_cur)
                            PH_VERSION:
                            begin
                                if (value_ok_cur && match_index_cur == 4'd8)
                                begin
                                    phase_next       = PH_HNAME;
                                    match_index_next = '0;
                                    cand_next        = 2'b11;
                                    value_ok_next    = 1'b1;
                                    line_empty_next  = 1'b1;
                                end
                                else
                                begin
                                    phase_next = PH_BAD;
                                end
                            end
                            PH_HNAME, PH_HSKIP, PH_CWS, PH_CVAL, PH_LWS, PH_LVAL:
                            begin
                                if (phase_cur == PH_HNAME && line_empty_cur)
                                begin
                                    if (len_acc_cur != '0)
                                    begin
                                        phase_next      = PH_BODY;
                                        body_count_next = '0;
                                    end
                                    else
                                    begin
                                        phase_next = PH_DONE;
                                    end
                                end
                                else
                                begin
                                    if (phase_cur == PH_CVAL && value_ok_cur
                                        && match_index_cur == 4'd10)
                                    begin
                                        ka_next = 1'b1;
                                    end
                                    phase_next       = PH_HNAME;
                                    match_index_next = '0;
                                    cand_next        = 2'b11;
                                    value_ok_next    = 1'b1;
                                    line_empty_next  = 1'b1;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_BAD;
                            end
                        endcase
                    end
                end
                else if (data_byte == CH_CR)
                begin
                    prev_cr_next = 1'b1;
                end
                else if (data_byte == CH_LF)
                begin
                    phase_next = PH_BAD;
                end
                else
                begin
                    line_empty_next = 1'b0;
                    case (phase_cur)
                        PH_METHOD:
                        begin
                            if (ws)
                            begin
                                if (match_index_cur != 4'd3)
                                begin
                                    value_ok_next = 1'b0;
                                end
                                phase_next = PH_GAP1;
                            end
                            else if (match_index_cur < 4'd3 && lc == get_char(match_index_cur))
                            begin
                                match_index_next = match_index_cur + 1'b1;
                            end
                            else
                            begin
                                value_ok_next = 1'b0;
                            end
                        end
                        PH_GAP1, PH_URL:
                        begin
                            if (phase_cur == PH_URL && ws)
                            begin
                                if (url_len_cur == '0)
                                begin
                                    value_ok_next = 1'b0;
                                end
                                phase_next = PH_GAP2;
                            end
                            else if (!ws)
                            begin
                                // url byte; first byte of the url restarts prefix match
                                if (phase_cur == PH_GAP1)
                                begin
                                    phase_next       = PH_URL;
                                    match_index_next = '0;
                                    cand_next        = 2'b01;
                                end
                                if (url_len_cur != '0)
                                begin
                                    url_len_next = url_len_cur + 1'b1;
                                end
                                else if (match_index_next == 4'd0)
                                begin
                                    if (data_byte == CH_SLASH)
                                    begin
                                        url_start_next = byte_offset_cur;
                                        url_len_next   = OFF_W'(1);
                                    end
                                    cand_next = (lc == "h") ? 2'b01 : 2'b00;
                                end
                                else if (match_index_next < 4'd7)
                                begin
                                    if (lc != pfx_char(match_index_next))
                                    begin
                                        cand_next = 2'b00;
                                    end
                                end
                                else if (cand_next[0] && data_byte == CH_SLASH)
                                begin
                                    url_start_next = byte_offset_cur;
                                    url_len_next   = OFF_W'(1);
                                end
                                if (match_index_next < 4'd8)
                                begin
                                    match_index_next = match_index_next + 1'b1;
                                end
                            end
                        end
                        PH_GAP2:
                        begin
                            if (!ws)
                            begin
                                phase_next = PH_VERSION;
                                if (lc == ver_char(4'd0))
                                begin
                                    match_index_next = 4'd1;
                                end
                                else
                                begin
                                    match_index_next = 4'd0;
                                    value_ok_next    = 1'b0;
                                end
                            end
                        end
                        PH_VERSION:
                        begin
                            if (match_index_cur < 4'd8 && lc == ver_char(match_index_cur))
                            begin
                                match_index_next = match_index_cur + 1'b1;
                            end
                            else
                            begin
                                value_ok_next = 1'b0;
                            end
                        end
                        PH_HNAME:
                        begin
                            if (cand_cur[0] && (match_index_cur >= 4'd11
                                || lc != conn_char(match_index_cur)))
                            begin
                                cand_next[0] = 1'b0;
                            end
                            if (cand_cur[1] && (match_index_cur >= 4'd15
                                || lc != clen_char(match_index_cur)))
                            begin
                                cand_next[1] = 1'b0;
                            end
                            if (cand_next[0] && match_index_cur == 4'd10)
                            begin
                                phase_next       = PH_CWS;
                                match_index_next = '0;
                            end
                            else if (cand_next[1] && match_index_cur == 4'd14)
                            begin
                                phase_next   = PH_LWS;
                                len_acc_next = '0;
                            end
                            else if (cand_next == 2'b00)
                            begin
                                phase_next = PH_HSKIP;
                            end
                            else
                            begin
                                match_index_next = match_index_cur + 1'b1;
                            end
                        end
                        PH_CWS:
                        begin
                            if (!ws)
                            begin
                                phase_next    = PH_CVAL;
                                value_ok_next = 1'b1;
                                if (lc == ka_char(4'd0))
                                begin
                                    match_index_next = 4'd1;
                                end
                                else
                                begin
                                    match_index_next = 4'd0;
                                    value_ok_next    = 1'b0;
                                end
                            end
                        end
                        PH_CVAL:
                        begin
                            if (match_index_cur < 4'd10 && lc == ka_char(match_index_cur))
                            begin
                                match_index_next = match_index_cur + 1'b1;
                            end
                            else
                            begin
                                value_ok_next = 1'b0;
                            end
                        end
                        PH_LWS:
                        begin
                            if (!(ws || data_byte == CH_VT || data_byte == CH_FF))
                            begin
                                if (data_byte == CH_PLUS)
                                begin
                                    phase_next = PH_LVAL;
                                end
                                else if (is_digit)
                                begin
                                    phase_next   = PH_LVAL;
                                    len_acc_next = digit;
                                end
                                else
                                begin
                                    phase_next = PH_HSKIP;
                                end
                            end
                        end
                        PH_LVAL:
                        begin
                            if (is_digit)
                            begin
                                if (len_prod > {4'd0, LEN_MAX})
                                begin
                                    len_acc_next = LEN_MAX;
                                end
                                else
                                begin
                                    len_acc_next = len_prod[30:0];
                                end
                            end
                            else
                            begin
                                phase_next = PH_HSKIP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

    always_comb
    begin
        case (phase_next)
            PH_DONE: result.parse_status = ST_DONE;
            PH_BAD:  result.parse_status = ST_BAD;
            PH_LONG: result.parse_status = ST_LONG;
            default: result.parse_status = ST_BUSY;
        endcase
        result.keep_alive  = ka_next;
        result.body_length = len_acc_next;
        result.url_offset  = 11'(url_start_next);
        result.url_length  = 11'(url_len_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_METHOD;
            byte_offset_reg <= '0;
            match_index_reg <= '0;
            cand_reg        <= 2'b11;
            value_ok_reg    <= 1'b1;
            prev_cr_reg     <= 1'b0;
            len_acc_reg     <= '0;
            body_count_reg  <= '0;
            ka_reg          <= 1'b0;
            url_start_reg   <= '0;
            url_len_reg     <= '0;
            line_empty_reg  <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            byte_offset_reg <= byte_offset_next;
            match_index_reg <= match_index_next;
            cand_reg        <= cand_next;
            value_ok_reg    <= value_ok_next;
            prev_cr_reg     <= prev_cr_next;
            len_acc_reg     <= len_acc_next;
            body_count_reg  <= body_count_next;
            ka_reg          <= ka_next;
            url_start_reg   <= url_start_next;
            url_len_reg     <= url_len_next;
            line_empty_reg  <= line_empty_next;
        end
    end

    `HGRP_ASSERT_NEXT(a_final_holds, clk, rst_n,
        step_en && !new_request && (phase_reg == PH_DONE || phase_reg == PH_BAD
        || phase_reg == PH_LONG), phase_reg == $past(phase_reg))
    `HGRP_ASSERT_NOW(a_offset_bound, clk, rst_n, 1'b1, byte_offset_reg <= OFF_LIMIT)
    `HGRP_ASSERT_NOW(a_url_inside, clk, rst_n, url_len_reg != '0,
        ({1'b0, url_start_reg} + {1'b0, url_len_reg}) <= {1'b0, byte_offset_reg})
    `HGRP_ASSERT_NOW(a_body_bound, clk, rst_n, phase_reg == PH_BODY,
        body_count_reg < len_acc_reg)

endmodule

// File: rtl/core/http_get_request_parser_top.sv
// each accepted byte passes the input register, the core and then the result register to m_tdata
// throughput: one byte per cycle while the result register drains; the parse state loop updates once per byte
// an input register and a result register part the two sides of the stream
// reset: rst_n asynchronous active low, clears all parse state to the method phase
// and empties both registers
module http_get_request_parser_top #(
    parameter int unsigned MAX_REQUEST_BYTES = hgrp_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // new_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata    // parse_status, keep_alive, body_length, url_offset,
                                   // url_length
);
    import hgrp_pkg::*;
    `include "http_get_request_parser_top_defines.svh"

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_new_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    core_result;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hgrp_core #(
        .MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (advance),
        .data_byte  (in_byte_reg),
        .new_request(in_new_reg),
        .result     (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_new_reg  <= s_tuser;
        end
        if (advance)
        begin
            out_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = RESULT_W'(out_reg);

    `HGRP_ASSERT_NEXT(a_in_held, clk, rst_n, in_valid_reg && !advance,
        in_valid_reg && in_byte_reg == $past(in_byte_reg))
    `HGRP_ASSERT_NEXT(a_step_result, clk, rst_n, advance, out_valid_reg)
    `HGRP_ASSERT_NEXT(a_take_byte, clk, rst_n, s_tvalid && s_tready, in_valid_reg)

endmodule
